// File: rtl/a64_subset_execute_unit_core_assert.svh
// assertion macros for the a64 execute unit
`ifndef A64_SUBSET_EXECUTE_UNIT_CORE_ASSERT_SVH
`define A64_SUBSET_EXECUTE_UNIT_CORE_ASSERT_SVH
// implication checked on every clock unless in reset
`define A64_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define A64_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/a64_pkg.sv
// shared types and constants of the a64 execute unit
package a64_pkg;
  localparam logic [31:0] HALT_WORD = 32'h8a000000;
  localparam logic [4:0] ZERO_REG = 5'b11111;
  localparam logic [3:0] FLAGS_RESET = 4'b0100;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_HALT = 2'd1,
    ST_LDST = 2'd2,
    ST_UNSUP = 2'd3
  } status_t;

  // register file read ports and write request between exec and regs
  typedef struct packed {
    logic [4:0] rn;
    logic [4:0] rm;
    logic [4:0] ra;
  } rd_req_t;

  typedef struct packed {
    logic en;
    logic [4:0] idx;
    logic [63:0] value;
  } wr_req_t;
endpackage

// File: rtl/a64_subset_execute_unit_core.sv
// top level of the a64 integer execute unit
// a64 subset execute unit
// in channel: in_valid/in_stall carry one 32-bit instruction word per item,
// assumed fetched at the unit's own program counter.
// out channel: out_valid/out_stall carry one result word per instruction:
// status, next pc, register write (flag, index, value) and the nzcv flags.
// an accepted instruction is decoded, executed and committed to the register
// file, pc and flags in the cycle it is taken; its result word appears in the
// output register in the cycle after.
// throughput is one instruction per cycle while in_stall is low; the single
// pass through decode, barrel shifter, adder and the low-half multiplier
// (three 32x32 partial products) sets the cycle.
// while the output register holds a word the receiver has stalled, in_stall
// is high and no new word is taken; when the word is taken in the same cycle
// a new instruction is accepted too.
// reset (rst_n low, synchronous) clears the general registers, pc to zero, flags to
// z set, and empties the output register.
module a64_subset_execute_unit_core import a64_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [31:0] in_instruction,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] out_status,
  output logic [63:0] out_next_pc,
  output logic out_wrote_register,
  output logic [4:0] out_dest_index,
  output logic [63:0] out_dest_value,
  output logic [3:0] out_flags_nzcv
);
`include "a64_subset_execute_unit_core_assert.svh"
  logic [63:0] pc_r, pc_nxt;
  logic [3:0] flags_r, flags_nxt;
  logic out_valid_r;
  logic acc;
  rd_req_t rd;
  wr_req_t wr, wr_g;
  logic [63:0] rn_val, rm_val, ra_val;
  status_t st;

  assign in_stall = out_valid_r && out_stall;
  assign acc = in_valid && !in_stall;

  always_comb begin
    wr_g = wr;
    wr_g.en = wr.en && acc;
  end

  a64_regs u_regs (.clk(clk), .rst_n(rst_n), .rd(rd), .rn_val(rn_val),
    .rm_val(rm_val), .ra_val(ra_val), .wr(wr_g));

  a64_exec u_exec (.ins(in_instruction), .pc(pc_r), .flags(flags_r), .rd(rd),
    .rn_val(rn_val), .rm_val(rm_val), .ra_val(ra_val), .wr(wr), .status(st),
    .next_pc(pc_nxt), .flags_out(flags_nxt));

  // pc and flags commit together with the register write of the accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
      flags_r <= FLAGS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        pc_r <= pc_nxt;
        flags_r <= flags_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_status <= st;
      out_next_pc <= pc_nxt;
      out_wrote_register <= wr.en;
      out_dest_index <= wr.idx;
      out_dest_value <= wr.value;
      out_flags_nzcv <= flags_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `A64_ASSERT_NXT(a_acc_valid, acc, out_valid)
  `A64_ASSERT_IMP(a_stall_held, out_valid && out_stall, in_stall)
  `A64_ASSERT_NXT(a_flags_out, acc, out_flags_nzcv == flags_r)
  `A64_ASSERT_NXT(a_pc_out, acc, out_next_pc == pc_r)
endmodule

// File: rtl/a64_regs.sv
// general register file with a zero register, one write port
module a64_regs import a64_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  rd_req_t rd,
  output logic [63:0] rn_val,
  output logic [63:0] rm_val,
  output logic [63:0] ra_val,
  input  wr_req_t wr
);
  logic [63:0] regs_r [31];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 31; i++) begin
      if (!rst_n) begin
        regs_r[i] <= '0;
      end else if (wr.en && wr.idx == 5'(i)) begin
        regs_r[i] <= wr.value;
      end
    end
  end

  // a write lands at the clock edge, so the next word already reads it here
  assign rn_val = (rd.rn == ZERO_REG) ? 64'd0 : regs_r[rd.rn];
  assign rm_val = (rd.rm == ZERO_REG) ? 64'd0 : regs_r[rd.rm];
  assign ra_val = (rd.ra == ZERO_REG) ? 64'd0 : regs_r[rd.ra];
endmodule

// File: rtl/a64_exec.sv
// combinational decode and execute of one instruction word
module a64_exec import a64_pkg::*; (
  input  logic [31:0] ins,
  input  logic [63:0] pc,
  input  logic [3:0] flags,
  output rd_req_t rd,
  input  logic [63:0] rn_val,
  input  logic [63:0] rm_val,
  input  logic [63:0] ra_val,
  output wr_req_t wr,
  output status_t status,
  output logic [63:0] next_pc,
  output logic [3:0] flags_out
);
  logic is64;
  logic [63:0] m;
  logic [3:0] op0;
  logic [1:0] opc;
  logic [63:0] a, b, bb, r, ov, shv, prod, wv;
  logic [63:0] ma, mb, prod_ll;
  logic [31:0] prod_x;
  logic [64:0] sum;
  logic [5:0] amt;
  logic [1:0] hw;
  logic [5:0] sh;
  logic [63:0] imm;
  logic sub, setf, do_add, take, known, cout;
  logic [63:0] off;

  assign is64 = ins[31];
  assign m = is64 ? {64{1'b1}} : {32'd0, {32{1'b1}}};
  assign op0 = ins[28:25];
  assign opc = ins[30:29];
  assign hw = ins[22:21];
  assign sh = {hw, 4'd0};
  assign rd.rn = ins[9:5];
  assign rd.rm = ins[20:16];
  // movk reads its own destination through the accumulator port
  assign rd.ra = (op0 == 4'd9) ? ins[4:0] : ins[14:10];
  assign amt = is64 ? ins[15:10] : {1'b0, ins[14:10]};

  always_comb begin
    logic [63:0] v, sr;
    logic sgn;
    v = rm_val & m;
    sgn = is64 ? v[63] : v[31];
    sr = v >> amt;
    unique case (ins[23:22])
      2'd0: shv = (v << amt) & m;
      2'd1: shv = sr;
      2'd2: shv = sgn ? (sr | (m & ~(m >> amt))) : sr;
      default: shv = (amt == 6'd0) ? v :
        (((v >> amt) | (v << ((is64 ? 7'd64 : 7'd32) - {1'b0, amt}))) & m);
    endcase
  end

  // low half of the 64x64 product from three 32x32 partial products
  assign ma = rn_val & m;
  assign mb = rm_val & m;
  assign prod_ll = {32'd0, ma[31:0]} * {32'd0, mb[31:0]};
  assign prod_x = ma[31:0] * mb[63:32] + ma[63:32] * mb[31:0];
  assign prod = prod_ll + {prod_x, 32'd0};

  always_comb begin
    logic [3:0] cc;
    a = rn_val & m;
    b = '0;
    sub = opc[1];
    setf = 1'b0;
    do_add = 1'b0;
    wr = '0;
    wv = '0;
    status = ST_OK;
    next_pc = pc + 64'd4;
    flags_out = flags;
    imm = '0;
    take = 1'b0;
    known = 1'b1;
    off = '0;
    cc = ins[3:0];
    bb = '0; sum = '0; r = '0; ov = '0; cout = 1'b0;
    if (ins == HALT_WORD) begin
      status = ST_HALT;
      next_pc = pc;
    end else if (op0 == 4'd8 || op0 == 4'd9) begin
      if (ins[25:23] == 3'd2) begin
        b = {52'd0, ins[21:10]} << (ins[22] ? 12 : 0);
        do_add = 1'b1;
        setf = opc[0];
      end else if (ins[25:23] == 3'd5) begin
        imm = {48'd0, ins[20:5]} << sh;
        if (opc == 2'd1 || (!is64 && hw[1])) status = ST_UNSUP;
        else begin
          wr.en = 1'b1;
          if (opc == 2'd0) wv = ~imm;
          else if (opc == 2'd2) wv = imm;
          else wv = ((ra_val & m) & ~(64'hffff << sh)) | imm;
        end
      end else status = ST_UNSUP;
    end else if (op0 == 4'd5 || op0 == 4'd13) begin
      if (ins[28]) begin
        if (ins[24:21] != 4'd8) status = ST_UNSUP;
        else begin
          wr.en = 1'b1;
          wv = ins[15] ? (ra_val & m) - prod : (ra_val & m) + prod;
        end
      end else if (!is64 && ins[15]) status = ST_UNSUP;
      else if (ins[24]) begin
        if (ins[21] || ins[23:22] == 2'd3) status = ST_UNSUP;
        else begin
          b = shv;
          do_add = 1'b1;
          setf = opc[0];
        end
      end else begin
        b = ins[21] ? (~shv & m) : shv;
        unique case (opc)
          2'd1: wv = a | b;
          2'd2: wv = a ^ b;
          default: wv = a & b;
        endcase
        wr.en = 1'b1;
        if (opc == 2'd3) flags_out = {is64 ? wv[63] : wv[31], (wv & m) == '0, 2'b00};
      end
    end else if ((op0 & 4'd5) == 4'd4) begin
      status = ST_LDST;
    end else if (op0 == 4'd10 || op0 == 4'd11) begin
      if (ins[31:26] == 6'b000101) begin
        off = {{36{ins[25]}}, ins[25:0], 2'b00};
        next_pc = pc + off;
      end else if ((ins & 32'hfffffc1f) == 32'hd61f0000) begin
        next_pc = rn_val;
      end else if ((ins & 32'hff000010) == 32'h54000000) begin
        unique case (cc)
          4'h0: take = flags[2];
          4'h1: take = !flags[2];
          4'ha: take = flags[3] == flags[0];
          4'hb: take = flags[3] != flags[0];
          4'hc: take = !flags[2] && flags[3] == flags[0];
          4'hd: take = flags[2] || flags[3] != flags[0];
          4'he: take = 1'b1;
          default: known = 1'b0;
        endcase
        off = {{43{ins[23]}}, ins[23:5], 2'b00};
        if (!known) status = ST_UNSUP;
        else if (take) next_pc = pc + off;
      end else status = ST_UNSUP;
    end else status = ST_UNSUP;

    if (do_add) begin
      bb = (sub ? ~b : b) & m;
      sum = {1'b0, a} + {1'b0, bb} + {64'd0, sub};
      r = sum[63:0] & m;
      cout = is64 ? sum[64] : sum[32];
      ov = (a ^ r) & (bb ^ r);
      wv = r;
      wr.en = 1'b1;
      if (setf)
        flags_out = {is64 ? r[63] : r[31], r == '0, cout, is64 ? ov[63] : ov[31]};
    end
    wv = wv & m;
    // writes to the zero register are dropped
    if (ins[4:0] == ZERO_REG) wr.en = 1'b0;
    wr.idx = wr.en ? ins[4:0] : 5'd0;
    wr.value = wr.en ? wv : 64'd0;
  end
endmodule
